// ===== design/ecr_pkg.sv =====
// Shared types, widths and constants of the event counter and rate block.
package ecr_pkg;

  // Table geometry
  localparam int THREADS     = 8;
  localparam int EVENT_KINDS = 8;
  localparam int ENTRIES     = THREADS * EVENT_KINDS;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int TID_W   = 3;
  localparam int EID_W   = 3;
  localparam int TIME_W  = 64;
  localparam int CNT_W   = 64;
  localparam int RATE_W  = 48;
  localparam int TPS_W   = 32;
  localparam int ALPHA_W = 16;
  localparam int MIN_W   = 32;
  localparam int FRAC_W  = 16;

  // Stream packing
  localparam int IN_DATA_W  = ((TID_W + EID_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CNT_W + RATE_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  // Rate arithmetic: product, saturation split and step counts
  localparam int PROD_W    = CNT_W + TPS_W;
  localparam int SAT_SHIFT = RATE_W - FRAC_W;
  localparam int DIVD_W    = SAT_SHIFT + FRAC_W;
  localparam int MUL_STEPS = TPS_W;
  localparam int DIV_STEPS = DIVD_W;
  localparam int EMA_STEPS = ALPHA_W;
  localparam int STEP_W    = 6;

  // Register reset values
  localparam logic [TIME_W-1:0]  START_TIME_RST = '0;
  localparam logic [TPS_W-1:0]   TPS_RST        = TPS_W'(100000000);
  localparam logic [ALPHA_W-1:0] ALPHA_RST      = ALPHA_W'(6554);
  localparam logic [MIN_W-1:0]   MIN_RST        = MIN_W'(1000);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOG  = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_RATE = 2'd2
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_START_TIME = 2'd0,
    CFG_TPS        = 2'd1,
    CFG_ALPHA      = 2'd2,
    CFG_MIN_TICKS  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CHECK,
    ST_CALC,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_CHK,
    C_DIV,
    C_PREP,
    C_EMA,
    C_DONE
  } calc_state_t;

  // Request to the serial rate unit
  typedef struct packed {
    logic               start;
    logic [CNT_W-1:0]   delta;
    logic [TPS_W-1:0]   tps;
    logic [TIME_W-1:0]  elapsed;
    logic [ALPHA_W-1:0] alpha;
    logic [RATE_W-1:0]  avg;
  } calc_req_t;

  // Response of the serial rate unit
  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] avg;
  } calc_rsp_t;

endpackage

// ===== design/ecr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ecr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ecr_rate_calc.sv =====
// Bit-serial rate unit: delta times ticks, long division, moving average step.
module ecr_rate_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  ecr_pkg::calc_req_t req,
  output ecr_pkg::calc_rsp_t rsp
);
  import ecr_pkg::*;

  calc_state_t state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   mul_r, mul_nxt;
  logic [CNT_W-1:0]    delta_r, delta_nxt;
  logic [TIME_W-1:0]   elap_r, elap_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [DIVD_W-1:0]   dvd_r, dvd_nxt;
  logic [RATE_W-1:0]   quo_r, quo_nxt;
  logic [RATE_W-1:0]   avg_r, avg_nxt;
  logic                ge_r, ge_nxt;
  logic [RATE_W-1:0]   diff_r, diff_nxt;
  logic [RATE_W+ALPHA_W-1:0] ema_r, ema_nxt;

  logic [CNT_W:0]      msum;
  logic [TIME_W+1:0]   trial;
  logic [RATE_W:0]     esum;
  logic [RATE_W-1:0]   step;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk) begin
    mul_r   <= mul_nxt;
    delta_r <= delta_nxt;
    elap_r  <= elap_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    quo_r   <= quo_nxt;
    avg_r   <= avg_nxt;
    ge_r    <= ge_nxt;
    diff_r  <= diff_nxt;
    ema_r   <= ema_nxt;
  end

  // Sequence the multiply, divide and average steps
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mul_nxt   = mul_r;
    delta_nxt = delta_r;
    elap_nxt  = elap_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    quo_nxt   = quo_r;
    avg_nxt   = avg_r;
    ge_nxt    = ge_r;
    diff_nxt  = diff_r;
    ema_nxt   = ema_r;

    msum  = {1'b0, mul_r[PROD_W-1:TPS_W]} + (mul_r[0] ? {1'b0, delta_r} : '0);
    trial = {1'b0, rem_r, dvd_r[DIVD_W-1]} - {2'b00, elap_r};
    esum  = {1'b0, ema_r[RATE_W+ALPHA_W-1:ALPHA_W]} + (ema_r[0] ? {1'b0, diff_r} : '0);

    unique case (state_r)
      C_IDLE: begin
        if (req.start) begin
          delta_nxt = req.delta;
          elap_nxt  = req.elapsed;
          avg_nxt   = req.avg;
          mul_nxt   = {{CNT_W{1'b0}}, req.tps};
          cnt_nxt   = STEP_W'(MUL_STEPS - 1);
          state_nxt = C_MUL;
        end
      end
      // Shift-add one multiplier bit per cycle
      C_MUL: begin
        mul_nxt = {msum, mul_r[TPS_W-1:1]};
        if (cnt_r == '0) begin
          state_nxt = C_CHK;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      // Saturate when the quotient cannot fit the rate field
      C_CHK: begin
        if (mul_r[PROD_W-1:SAT_SHIFT] >= elap_r) begin
          quo_nxt   = '1;
          state_nxt = C_PREP;
        end else begin
          rem_nxt   = mul_r[PROD_W-1:SAT_SHIFT];
          dvd_nxt   = {mul_r[SAT_SHIFT-1:0], {FRAC_W{1'b0}}};
          quo_nxt   = '0;
          cnt_nxt   = STEP_W'(DIV_STEPS - 1);
          state_nxt = C_DIV;
        end
      end
      // Restoring division, one quotient bit per cycle
      C_DIV: begin
        if (!trial[TIME_W+1]) begin
          rem_nxt = trial[TIME_W-1:0];
        end else begin
          rem_nxt = {rem_r[TIME_W-2:0], dvd_r[DIVD_W-1]};
        end
        quo_nxt = {quo_r[RATE_W-2:0], ~trial[TIME_W+1]};
        dvd_nxt = {dvd_r[DIVD_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = C_PREP;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      // Take the distance between new sample and old average
      C_PREP: begin
        ge_nxt    = (quo_r >= avg_r);
        diff_nxt  = (quo_r >= avg_r) ? (quo_r - avg_r) : (avg_r - quo_r);
        ema_nxt   = {{RATE_W{1'b0}}, req.alpha};
        cnt_nxt   = STEP_W'(EMA_STEPS - 1);
        state_nxt = C_EMA;
      end
      // Scale the distance by alpha, one bit per cycle
      C_EMA: begin
        ema_nxt = {esum, ema_r[ALPHA_W-1:1]};
        if (cnt_r == '0) begin
          state_nxt = C_DONE;
        end else begin
          cnt_nxt = cnt_r - STEP_W'(1);
        end
      end
      C_DONE: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  // Step toward the new sample, truncated toward the old average
  assign step     = ema_r[RATE_W+ALPHA_W-1:ALPHA_W];
  assign rsp.done = (state_r == C_DONE);
  assign rsp.avg  = ge_r ? (avg_r + step) : (avg_r - step);

endmodule

// ===== design/event_counter_rate_ema_top.sv =====
// Event counter table with bit-serial smoothed rate measurement.
// Each in-range item passes the read, evaluate and output states; a rate item adds
// a check state, and a valid sample a run of the serial rate unit (32 multiply, 48
// divide and 16 scaling steps, one bit a cycle; no divide when it saturates).
// One item in work at a time; a result waiting at the output does not block the next.
// Reset (synchronous, rst_n low) clears all counters and averages at once.
module event_counter_rate_ema_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // thread_id[2:0], event_id[5:3], timestamp[69:6], zero fill above
  input  logic [ecr_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[1:0]
  input  logic [ecr_pkg::FUNC_W-1:0]      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // count[63:0], rate[111:64]
  output logic [ecr_pkg::OUT_DATA_W-1:0]  out_tdata,
  // rate_updated[0]
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [ecr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ecr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ecr_pkg::*;

  localparam int META_W = TIME_W + CNT_W + RATE_W;

  state_t state_r, state_nxt;

  logic [TIME_W-1:0]  start_time_r;
  logic [TPS_W-1:0]   tps_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [MIN_W-1:0]   min_r;

  logic [ENTRIES-1:0] cnt_vld_r;
  logic [ENTRIES-1:0] seen_r;

  func_t              func_r;
  logic [IDX_W-1:0]   idx_r;
  logic [TIME_W-1:0]  ts_r;
  logic [CNT_W-1:0]   count_r;
  logic [RATE_W-1:0]  avg_r;
  logic               upd_r;
  logic [TIME_W-1:0]  elap_r;
  logic               early_r;
  logic [CNT_W-1:0]   delta_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  logic                  in_acc;
  logic [TID_W-1:0]      in_tid;
  logic [EID_W-1:0]      in_eid;
  logic [TIME_W-1:0]     in_ts;
  logic [31:0]           idx_full;
  logic                  in_range;

  logic                  cnt_we;
  logic [CNT_W-1:0]      cnt_rdata;
  logic                  meta_we;
  logic [META_W-1:0]     meta_wdata;
  logic [META_W-1:0]     meta_rdata;
  logic                  mem_re;

  logic [CNT_W-1:0]      cnt_cur;
  logic                  seen_cur;
  logic [TIME_W-1:0]     prev_time;
  logic [CNT_W-1:0]      prev_count;
  logic [RATE_W-1:0]     prev_avg;
  logic [TIME_W:0]       elap_ext;
  logic                  sample_ok;
  logic                  out_load;

  calc_req_t             calc_req;
  calc_rsp_t             calc_rsp;

  // Unpack the request
  assign in_tid   = in_tdata[TID_W-1:0];
  assign in_eid   = in_tdata[TID_W+EID_W-1:TID_W];
  assign in_ts    = in_tdata[TID_W+EID_W+TIME_W-1:TID_W+EID_W];
  assign in_acc   = in_tvalid && in_tready;
  assign idx_full = 32'(in_tid) * 32'(EVENT_KINDS) + 32'(in_eid);
  assign in_range = (32'(in_tid) < 32'(THREADS)) && (32'(in_eid) < 32'(EVENT_KINDS));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= START_TIME_RST;
      tps_r        <= TPS_RST;
      alpha_r      <= ALPHA_RST;
      min_r        <= MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_START_TIME: start_time_r <= cfg_wdata[TIME_W-1:0];
        CFG_TPS:        tps_r        <= cfg_wdata[TPS_W-1:0];
        CFG_ALPHA:      alpha_r      <= cfg_wdata[ALPHA_W-1:0];
        CFG_MIN_TICKS:  min_r        <= cfg_wdata[MIN_W-1:0];
      endcase
    end
  end

  // Entry stores: counters, and time/count/average of the last sample
  assign mem_re     = (state_r == ST_READ);
  assign cnt_we     = (state_r == ST_EVAL) && (func_r == FUNC_LOG);
  assign meta_we    = (state_r == ST_CALC) && calc_rsp.done;
  assign meta_wdata = {calc_rsp.avg, count_r, ts_r};

  ecr_ram #(
    .WIDTH (CNT_W),
    .DEPTH (ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (idx_r),
    .wdata (cnt_cur + CNT_W'(1)),
    .re    (mem_re),
    .raddr (idx_r),
    .rdata (cnt_rdata)
  );

  ecr_ram #(
    .WIDTH (META_W),
    .DEPTH (ENTRIES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (idx_r),
    .wdata (meta_wdata),
    .re    (mem_re),
    .raddr (idx_r),
    .rdata (meta_rdata)
  );

  // Entries never written read as their reset values
  assign cnt_cur    = cnt_vld_r[idx_r] ? cnt_rdata : '0;
  assign seen_cur   = seen_r[idx_r];
  assign prev_time  = seen_cur ? meta_rdata[TIME_W-1:0] : start_time_r;
  assign prev_count = seen_cur ? meta_rdata[TIME_W+CNT_W-1:TIME_W] : '0;
  assign prev_avg   = seen_cur ? meta_rdata[META_W-1:TIME_W+CNT_W] : '0;
  assign elap_ext   = {1'b0, ts_r} - {1'b0, prev_time};

  // A sample needs a positive interval no shorter than the minimum
  assign sample_ok = !early_r && (elap_r != '0) && (elap_r >= TIME_W'(min_r));
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // Serial rate unit
  assign calc_req.start   = (state_r == ST_CHECK) && sample_ok;
  assign calc_req.delta   = delta_r;
  assign calc_req.tps     = tps_r;
  assign calc_req.elapsed = elap_r;
  assign calc_req.alpha   = alpha_r;
  assign calc_req.avg     = avg_r;

  ecr_rate_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = in_range ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = (func_r == FUNC_RATE) ? ST_CHECK : ST_OUT;
      end
      ST_CHECK: begin
        state_nxt = sample_ok ? ST_CALC : ST_OUT;
      end
      ST_CALC: begin
        if (calc_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Valid bits: counter written, sample taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      seen_r    <= '0;
    end else begin
      if (cnt_we) begin
        cnt_vld_r[idx_r] <= 1'b1;
      end
      if (meta_we) begin
        seen_r[idx_r] <= 1'b1;
      end
    end
  end

  // Item and result datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= func_t'(in_tuser);
      idx_r   <= idx_full[IDX_W-1:0];
      ts_r    <= in_ts;
      count_r <= '0;
      avg_r   <= '0;
      upd_r   <= 1'b0;
    end
    if (state_r == ST_EVAL) begin
      count_r <= (func_r == FUNC_LOG) ? (cnt_cur + CNT_W'(1)) : cnt_cur;
      avg_r   <= prev_avg;
      elap_r  <= elap_ext[TIME_W-1:0];
      early_r <= elap_ext[TIME_W];
      delta_r <= cnt_cur - prev_count;
    end
    if (meta_we) begin
      avg_r <= calc_rsp.avg;
      upd_r <= 1'b1;
    end
  end

  // Output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({avg_r, count_r});
      out_user_r <= upd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking stream testbench for the event counter and smoothed rate table.
`timescale 1ns / 1ps

module tb_top;
  import ecr_pkg::*;

  // Unused function code: behaves like a read
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam logic [127:0] RATE_MAX = (128'd1 << RATE_W) - 128'd1;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  tid;
    logic [EID_W-1:0]  eid;
    logic [TIME_W-1:0] ts;
  } counter_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [RATE_W-1:0] rate;
    logic              sampled;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Own copy of the registers
  logic [TIME_W-1:0]  start_ticks = START_TIME_RST;
  logic [TPS_W-1:0]   tps = TPS_RST;
  logic [ALPHA_W-1:0] alpha = ALPHA_RST;
  logic [MIN_W-1:0]   min_ticks = MIN_RST;

  // Own copy of the counter table
  logic [CNT_W-1:0]  count_tbl [ENTRIES] = '{default: '0};
  logic [TIME_W-1:0] time_tbl  [ENTRIES] = '{default: '0};
  logic              seen_tbl  [ENTRIES] = '{default: 1'b0};
  logic [CNT_W-1:0]  base_tbl  [ENTRIES] = '{default: '0};
  logic [RATE_W-1:0] avg_tbl   [ENTRIES] = '{default: '0};

  counter_req_t req_q[$];
  tally_t       tally_q[$];
  counter_req_t offered;
  logic [TIME_W-1:0] now_ticks = 64'd10000;

  int fail_cnt = 0;
  int results_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [7:0] stall_phase = '0;
  int quiet_cycles = 0;

  event_counter_rate_ema_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Instantaneous rate in Q32.16, saturated; span is never zero here
  function automatic logic [RATE_W-1:0] inst_rate_of(input logic [CNT_W-1:0] delta,
                                                     input logic [TPS_W-1:0] t,
                                                     input logic [TIME_W-1:0] span);
    logic [127:0] num;
    logic [127:0] quo;
    num = {64'd0, delta} * {96'd0, t};
    num = num << FRAC_W;
    quo = num / {64'd0, span};
    if (quo > RATE_MAX) return RATE_MAX[RATE_W-1:0];
    return quo[RATE_W-1:0];
  endfunction

  // Move the average toward the new rate, truncating toward the old value
  function automatic logic [RATE_W-1:0] ema_of(input logic [RATE_W-1:0] avg,
                                               input logic [RATE_W-1:0] r,
                                               input logic [ALPHA_W-1:0] a);
    logic [63:0] step;
    if (r >= avg) begin
      step = (64'(r - avg) * 64'(a)) >> FRAC_W;
      return avg + step[RATE_W-1:0];
    end
    step = (64'(avg - r) * 64'(a)) >> FRAC_W;
    return avg - step[RATE_W-1:0];
  endfunction

  // Apply one request to the table copy and return the result it gives
  function automatic tally_t apply_to_table(input counter_req_t r);
    int idx;
    logic [TIME_W-1:0] prev;
    logic [TIME_W-1:0] span;
    logic [RATE_W-1:0] fresh;
    tally_t res;
    res = '0;
    if (int'(r.tid) >= THREADS || int'(r.eid) >= EVENT_KINDS) return res;
    idx = int'(r.tid) * EVENT_KINDS + int'(r.eid);
    if (r.func == FUNC_LOG) begin
      count_tbl[idx] = count_tbl[idx] + 64'd1;
    end else if (r.func == FUNC_RATE) begin
      prev = seen_tbl[idx] ? time_tbl[idx] : start_ticks;
      if (r.ts >= prev) begin
        span = r.ts - prev;
        if (span != 0 && span >= 64'(min_ticks)) begin
          fresh = inst_rate_of(count_tbl[idx] - base_tbl[idx], tps, span);
          avg_tbl[idx] = ema_of(avg_tbl[idx], fresh, alpha);
          time_tbl[idx] = r.ts;
          seen_tbl[idx] = 1'b1;
          base_tbl[idx] = count_tbl[idx];
          res.sampled = 1'b1;
        end
      end
    end
    res.count = count_tbl[idx];
    res.rate = avg_tbl[idx];
    return res;
  endfunction

  // Sender: bursts of requests with random gaps, data held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        tally_q.push_back(apply_to_table(offered));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          offered = req_q.pop_front();
          in_tdata <= IN_DATA_W'({offered.ts, offered.eid, offered.tid});
          in_tuser <= offered.func;
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
            gap_left = $urandom_range(0, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, stall on its own pattern, hold off once
  always @(posedge clk) begin : result_check
    tally_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (tally_q.size() == 0) begin
        $error("unexpected result: count %0h", out_tdata[CNT_W-1:0]);
        fail_cnt++;
      end else begin
        want = tally_q.pop_front();
        if (out_tdata[CNT_W-1:0] !== want.count) begin
          $error("count: expected %0h, got %0h", want.count, out_tdata[CNT_W-1:0]);
          fail_cnt++;
        end
        if (out_tdata[CNT_W +: RATE_W] !== want.rate) begin
          $error("rate: expected %0h, got %0h", want.rate, out_tdata[CNT_W +: RATE_W]);
          fail_cnt++;
        end
        if (out_tuser !== want.sampled) begin
          $error("rate_updated: expected %0b, got %0b", want.sampled, out_tuser);
          fail_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_phase[7]) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 2) != 0);
    end
    stall_phase <= stall_phase + 8'd1;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("event_counter_rate_ema_top test failed");
      $finish;
    end
  end

  task automatic queue_req(input logic [FUNC_W-1:0] f, input logic [TID_W-1:0] t,
                           input logic [EID_W-1:0] e, input logic [TIME_W-1:0] ts);
    counter_req_t r;
    r.func = f;
    r.tid = t;
    r.eid = e;
    r.ts = ts;
    req_q.push_back(r);
  endtask

  // Write one register and track it in the local copy
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_START_TIME: start_ticks = value;
      CFG_TPS:        tps = value[TPS_W-1:0];
      CFG_ALPHA:      alpha = value[ALPHA_W-1:0];
      CFG_MIN_TICKS:  min_ticks = value[MIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request is sent and every result has come back
  task automatic drain;
    @(negedge clk);
    while (req_q.size() != 0 || tally_q.size() != 0 || in_tvalid) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Random requests: mostly hot entries and timestamps that move forward
  task automatic run_phase(input int mode, input int n);
    logic [TID_W-1:0] t;
    logic [EID_W-1:0] e;
    logic [FUNC_W-1:0] f;
    logic [TIME_W-1:0] ts;
    int h;
    int sel;
    int noise;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        h = $urandom_range(0, 7);
        t = TID_W'(h);
        e = EID_W'(h) ^ 3'd5;
      end else begin
        t = TID_W'($urandom_range(0, 7));
        e = EID_W'($urandom_range(0, 7));
      end
      sel = $urandom_range(0, 99);
      if (sel < 48) f = FUNC_LOG;
      else if (sel < 60) f = FUNC_READ;
      else if (sel < 63) f = FUNC_SPARE;
      else f = FUNC_RATE;
      case (mode)
        1: now_ticks += 64'($urandom_range(0, 20));
        2: now_ticks += (f == FUNC_RATE) ? (64'd1 << 32) + 64'($urandom_range(0, 1 << 20))
                                         : 64'($urandom_range(0, 100));
        3: now_ticks += 64'($urandom_range(0, 800));
        4: now_ticks += 64'($urandom_range(0, 100));
        default: now_ticks += 64'($urandom_range(0, 600));
      endcase
      if (f == FUNC_RATE) begin
        noise = $urandom_range(0, 19);
        if (noise == 0) ts = now_ticks - 64'($urandom_range(1, 5000));
        else if (noise == 1 && $urandom_range(0, 9) == 0) ts = {$urandom, $urandom};
        else ts = now_ticks;
      end else begin
        ts = {$urandom, $urandom};
      end
      queue_req(f, t, e, ts);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: short, behind, exact-minimum and huge intervals at reset settings
    @(negedge clk);
    queue_req(FUNC_READ, 3'd0, 3'd0, 64'd0);
    repeat (3) queue_req(FUNC_LOG, 3'd0, 3'd0, {$urandom, $urandom});
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd500);
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd5000);
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd4000);
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd5999);
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd6000);
    queue_req(FUNC_LOG, 3'd7, 3'd7, '1);
    queue_req(FUNC_SPARE, 3'd7, 3'd7, '1);
    queue_req(FUNC_RATE, 3'd7, 3'd7, '1);
    queue_req(FUNC_RATE, 3'd7, 3'd7, '1);
    queue_req(FUNC_READ, 3'd5, 3'd2, 64'd0);
    queue_req(FUNC_LOG, 3'd2, 3'd5, 64'd0);
    queue_req(FUNC_RATE, 3'd2, 3'd5, 64'd2000);
    drain();

    // Directed: zero elapsed from a start time at the top and from a sample
    write_reg(CFG_MIN_TICKS, '0);
    write_reg(CFG_START_TIME, '1);
    @(negedge clk);
    queue_req(FUNC_RATE, 3'd3, 3'd4, '1);
    queue_req(FUNC_RATE, 3'd3, 3'd4, 64'd100);
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd6000);
    drain();

    // Directed: zero ticks per second, then saturation with full alpha
    write_reg(CFG_TPS, '0);
    @(negedge clk);
    queue_req(FUNC_LOG, 3'd0, 3'd0, 64'd0);
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd9000);
    drain();
    write_reg(CFG_TPS, 64'hFFFF_FFFF);
    write_reg(CFG_ALPHA, 64'hFFFF);
    @(negedge clk);
    repeat (2) queue_req(FUNC_LOG, 3'd0, 3'd0, 64'd0);
    queue_req(FUNC_RATE, 3'd0, 3'd0, 64'd9001);
    drain();

    // Random phases across register settings
    for (int mode = 0; mode < 5; mode++) begin
      case (mode)
        0: begin
          write_reg(CFG_START_TIME, '0);
          write_reg(CFG_TPS, 64'(TPS_RST));
          write_reg(CFG_ALPHA, 64'(ALPHA_RST));
          write_reg(CFG_MIN_TICKS, 64'(MIN_RST));
        end
        1: begin
          write_reg(CFG_START_TIME, now_ticks);
          write_reg(CFG_TPS, 64'hFFFF_FFFF);
          write_reg(CFG_ALPHA, 64'hFFFF);
          write_reg(CFG_MIN_TICKS, '0);
        end
        2: begin
          write_reg(CFG_START_TIME, now_ticks - 64'($urandom_range(0, 1000000)));
          write_reg(CFG_TPS, 64'd1);
          write_reg(CFG_ALPHA, '0);
          write_reg(CFG_MIN_TICKS, 64'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_START_TIME, {$urandom, $urandom});
          write_reg(CFG_TPS, {$urandom, $urandom});
          write_reg(CFG_ALPHA, {$urandom, $urandom});
          write_reg(CFG_MIN_TICKS, {$urandom, 32'($urandom_range(0, 5000))});
        end
        default: begin
          write_reg(CFG_START_TIME, now_ticks);
          write_reg(CFG_TPS, 64'($urandom_range(1, 1000000)));
          write_reg(CFG_ALPHA, 64'($urandom_range(0, 65535)));
          write_reg(CFG_MIN_TICKS, 64'($urandom_range(0, 200)));
        end
      endcase
      run_phase(mode, 165);
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && tally_q.size() == 0) begin
      $display("event_counter_rate_ema_top test passed");
    end else begin
      $display("event_counter_rate_ema_top test failed");
    end
    $finish;
  end

endmodule
